// ----- rtl/core/sct_pkg.sv -----
// Shared types and constants for the sparse transpose scatter engine.
package sct_pkg;

	// Item field widths
	localparam int OP_W   = 3;
	localparam int IDX_W  = 12;
	localparam int OFS_W  = 13;
	localparam int DATA_W = 64;
	localparam int POS_W  = 12;

	// Input tdata layout: index, offset, data_in from bit 0 up, padded to bytes
	localparam int S_IDX_LSB   = 0;
	localparam int S_OFS_LSB   = S_IDX_LSB + IDX_W;
	localparam int S_DIN_LSB   = S_OFS_LSB + OFS_W;
	localparam int S_USED_W    = S_DIN_LSB + DATA_W;
	localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

	// Output tdata layout: position, data_out from bit 0 up, padded to bytes
	localparam int M_POS_LSB   = 0;
	localparam int M_DOUT_LSB  = M_POS_LSB + POS_W;
	localparam int M_USED_W    = M_DOUT_LSB + DATA_W;
	localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

	// Opcodes
	localparam logic [OP_W-1:0] OP_SET_OFS = 3'd0;
	localparam logic [OP_W-1:0] OP_PLACE   = 3'd1;
	localparam logic [OP_W-1:0] OP_TAKE    = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;

	// Status codes
	localparam logic ST_OK    = 1'b0;
	localparam logic ST_RANGE = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CTR  = 4'b0010,
		S_STO  = 4'b0100,
		S_PUSH = 4'b1000
	} state_t;

endpackage

// ----- rtl/core/sct_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
module sct_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/sparse_csc_transpose_scatter.sv -----
// Top level of the compressed-column transpose scatter engine.
//
// The engine keeps one running position counter per source row in a counter
// RAM and the transposed 64-bit words in a value RAM, both synchronous with
// a registered read port. Items are handled one at a time: the counter RAM
// is read on the accept edge, the counter is checked and updated in the next
// cycle, and take and read items pass through S_STO for the value RAM read.
// An item runs through S_CTR and S_PUSH (set offset, place, write store, range
// errors, unknown opcodes) or S_CTR, S_STO and S_PUSH (reverse take, read store),
// and waits in S_PUSH for a free output register; the result register lets the
// next item be accepted while the previous result is still unclaimed.
// Neither RAM is cleared: a row counter or store entry read before it was
// written returns whatever the RAM holds. Offsets up to MAX_NONZEROS are legal
// end positions; a counter or index at or above MAX_NONZEROS, or a row at or
// above MAX_ROWS, leaves all state unchanged and returns status 1 with zero
// position and data. Unknown opcodes return an all-zero result.
module sparse_csc_transpose_scatter
	import sct_pkg::*;
#(
	parameter int MAX_ROWS     = 1024,
	parameter int MAX_NONZEROS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// s_axis_tdata: index[11:0], offset[24:12], data_in[88:25], zero pad
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// s_axis_tuser: opcode[2:0]
	input  logic [OP_W-1:0]      s_axis_tuser,
	// m_axis_tdata: position[11:0], data_out[75:12], zero pad
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// m_axis_tuser: status[0]
	output logic                 m_axis_tuser
);

	// Counters must hold any 13-bit offset and the end position MAX_NONZEROS
	localparam int CNT_NEED = $clog2(MAX_NONZEROS + 1);
	localparam int CNT_W    = (CNT_NEED > OFS_W) ? CNT_NEED : OFS_W;
	localparam int RA_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SA_W     = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;

	state_t state_q;

	// Accepted item
	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [OFS_W-1:0]  ofs_q;
	logic [DATA_W-1:0] din_q;

	// Pending result
	logic [POS_W-1:0]  res_pos_q;
	logic [DATA_W-1:0] res_data_q;
	logic              res_st_q;

	// Output register
	logic              m_valid_q;
	logic [POS_W-1:0]  m_pos_q;
	logic [DATA_W-1:0] m_data_q;
	logic              m_st_q;

	logic [SA_W-1:0]   pos_q;

	// RAM ports
	logic              ctr_we, ctr_re;
	logic [RA_W-1:0]   ctr_waddr, ctr_raddr;
	logic [CNT_W-1:0]  ctr_wdata, ctr_rdata;
	logic              sto_we, sto_re;
	logic [SA_W-1:0]   sto_waddr, sto_raddr;
	logic [DATA_W-1:0] sto_wdata, sto_rdata;

	logic in_fire, out_load;
	logic row_bad, pos_bad, sto_bad;
	logic is_ctr_op;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == S_PUSH) && (!m_valid_q || m_axis_tready);

	assign s_axis_tready = (state_q == S_IDLE);

	// Range checks, valid in S_CTR
	assign row_bad   = 32'(idx_q) >= 32'(MAX_ROWS);
	assign pos_bad   = 32'(ctr_rdata) >= 32'(MAX_NONZEROS);
	assign sto_bad   = 32'(idx_q) >= 32'(MAX_NONZEROS);
	assign is_ctr_op = (op_q == OP_PLACE) || (op_q == OP_TAKE);

	// Counter RAM: read on accept, written back in S_CTR
	assign ctr_re    = in_fire;
	assign ctr_raddr = RA_W'(s_axis_tdata[S_IDX_LSB +: IDX_W]);
	assign ctr_waddr = RA_W'(idx_q);

	always_comb begin
		ctr_we    = 1'b0;
		ctr_wdata = CNT_W'(ofs_q);
		if (state_q == S_CTR && !row_bad) begin
			if (op_q == OP_SET_OFS) begin
				ctr_we = 1'b1;
			end else if (is_ctr_op && !pos_bad) begin
				ctr_we    = 1'b1;
				ctr_wdata = ctr_rdata + CNT_W'(1);
			end
		end
	end

	// Value RAM: place and write store, take and read issue reads in S_CTR; take clears its entry in S_STO
	always_comb begin
		sto_we    = 1'b0;
		sto_waddr = SA_W'(idx_q);
		sto_wdata = din_q;
		sto_re    = 1'b0;
		sto_raddr = SA_W'(idx_q);
		case (state_q)
			S_CTR: begin
				if (is_ctr_op && !row_bad && !pos_bad) begin
					sto_waddr = SA_W'(ctr_rdata);
					sto_raddr = SA_W'(ctr_rdata);
					sto_we    = (op_q == OP_PLACE);
					sto_re    = (op_q == OP_TAKE);
				end else if (op_q == OP_WRITE && !sto_bad) begin
					sto_we = 1'b1;
				end else if (op_q == OP_READ && !sto_bad) begin
					sto_re = 1'b1;
				end
			end
			S_STO: begin
				if (op_q == OP_TAKE) begin
					sto_we    = 1'b1;
					sto_waddr = pos_q;
					sto_wdata = '0;
				end
			end
			default: begin
			end
		endcase
	end

	sct_ram #(
		.DEPTH (MAX_ROWS),
		.WIDTH (CNT_W)
	) u_ctr_ram (
		.clk   (clk),
		.we    (ctr_we),
		.waddr (ctr_waddr),
		.wdata (ctr_wdata),
		.re    (ctr_re),
		.raddr (ctr_raddr),
		.rdata (ctr_rdata)
	);

	sct_ram #(
		.DEPTH (MAX_NONZEROS),
		.WIDTH (DATA_W)
	) u_sto_ram (
		.clk   (clk),
		.we    (sto_we),
		.waddr (sto_waddr),
		.wdata (sto_wdata),
		.re    (sto_re),
		.raddr (sto_raddr),
		.rdata (sto_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) state_q <= S_CTR;
				end
				S_CTR: begin
					if (sto_re) state_q <= S_STO;
					else        state_q <= S_PUSH;
				end
				S_STO: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= s_axis_tuser;
			idx_q <= s_axis_tdata[S_IDX_LSB +: IDX_W];
			ofs_q <= s_axis_tdata[S_OFS_LSB +: OFS_W];
			din_q <= s_axis_tdata[S_DIN_LSB +: DATA_W];
		end
	end

	// Result build
	always_ff @(posedge clk) begin
		if (state_q == S_CTR) begin
			pos_q      <= SA_W'(ctr_rdata);
			res_pos_q  <= '0;
			res_data_q <= '0;
			res_st_q   <= ST_OK;
			case (op_q)
				OP_SET_OFS: begin
					res_st_q <= row_bad ? ST_RANGE : ST_OK;
				end
				OP_PLACE, OP_TAKE: begin
					if (row_bad || pos_bad) begin
						res_st_q <= ST_RANGE;
					end else begin
						res_pos_q <= POS_W'(ctr_rdata);
					end
				end
				OP_WRITE, OP_READ: begin
					if (sto_bad) begin
						res_st_q <= ST_RANGE;
					end else begin
						res_pos_q <= POS_W'(idx_q);
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == S_STO) begin
			if (op_q == OP_TAKE) res_data_q <= din_q | sto_rdata;
			else                 res_data_q <= sto_rdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_pos_q  <= res_pos_q;
			m_data_q <= res_data_q;
			m_st_q   <= res_st_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_st_q;
	assign m_axis_tdata  = M_TDATA_W'({m_data_q, m_pos_q});

endmodule

// ----- rtl/core/sct_checker.sv -----
// Port-level checks for the transpose scatter engine, bound to the top level.
module sct_checker
	import sct_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tuser
);

	logic       in_fire, out_fire;
	logic [1:0] open_q;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// Items accepted whose result has not been taken yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 2'd0;
		end else if (in_fire && !out_fire) begin
			open_q <= open_q + 2'd1;
		end else if (out_fire && !in_fire) begin
			open_q <= open_q - 2'd1;
		end
	end

	// A result never shows without an item behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (open_q != 2'd0))
		else $error("result without an open item");

	// One item at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready)
		else $error("input accepted while an item is in flight");

	// Range errors return zero position and data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("error result carries payload");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

	// Open items never exceed one in work plus one in the output register
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q != 2'd3)
		else $error("too many open items");

endmodule

bind sparse_csc_transpose_scatter sct_checker u_sct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
